// ===== hdl/ubx_pkg.sv =====
// Shared constants and types for the UBX frame deframer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ubx_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    typedef enum logic [1:0] {
        EV_DATA = 2'd0,
        EV_GOOD = 2'd1,
        EV_BAD  = 2'd2,
        EV_DROP = 2'd3
    } event_kind_t;

endpackage

`default_nettype wire

// ===== hdl/ubx_in_if.sv =====
// Byte input channel of the UBX deframer: valid/ready plus func and rx_byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ubx_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/ubx_out_if.sv =====
// Event output channel of the UBX deframer: valid/ready plus the event payload.
// Depends on ubx_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ubx_out_if;
    logic                valid;
    logic                ready;
    ubx_pkg::event_kind_t event_kind;
    logic [7:0]          msg_class;
    logic [7:0]          msg_ident;
    logic [8:0]          msg_length;
    logic [7:0]          data_byte;
    logic [7:0]          byte_index;

    modport source (output valid, output event_kind, output msg_class, output msg_ident,
                    output msg_length, output data_byte, output byte_index, input ready);
    modport sink   (input valid, input event_kind, input msg_class, input msg_ident,
                    input msg_length, input data_byte, input byte_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/ubx_frame_deframer.sv =====
// UBX deframer: sync hunt, header capture, Fletcher-8 check, payload, check-result and oversize-drop events.
// An accepted byte's event is in the output register in the cycle after the byte is accepted.
// Throughput: one byte per cycle; the output register is refilled in the cycle
// it is drained, so a new byte is taken whenever the event side is ready or empty.
// Reset (rst_n, async, active low): hunting for the first sync byte, sums and
// header fields cleared, no event pending. Depends on ubx_pkg, ubx_in_if, ubx_out_if.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_deframer #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ubx_in_if.sink    rx,
    ubx_out_if.source evt
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_IDENT   = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK_A    = 4'd7,
        PH_CK_B    = 4'd8
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [7:0]           class_reg, class_next;
    logic [7:0]           ident_reg, ident_next;
    logic [15:0]          length_reg, length_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [7:0]           sum_a_reg, sum_a_next;
    logic [7:0]           sum_b_reg, sum_b_next;

    logic                 out_valid_reg;
    ubx_pkg::event_kind_t kind_reg;
    logic [7:0]           oclass_reg;
    logic [7:0]           oident_reg;
    logic [8:0]           olength_reg;
    logic [7:0]           odata_reg;
    logic [7:0]           oindex_reg;

    logic                 accept;
    logic                 res_valid;
    ubx_pkg::event_kind_t res_kind;
    logic [8:0]           res_length;
    logic [7:0]           res_data;
    logic [7:0]           res_index;

    logic [7:0]           b;
    logic [7:0]           add_a;
    logic [7:0]           add_b;
    logic [15:0]          len_full;
    logic [CNT_W-1:0]     count_inc;

    assign rx.ready = !out_valid_reg || evt.ready;
    assign accept   = rx.valid && rx.ready;
    assign b        = rx.rx_byte;

    // running Fletcher step for the current byte
    assign add_a     = sum_a_reg + b;
    assign add_b     = sum_b_reg + add_a;
    assign len_full  = {b, length_reg[7:0]};
    assign count_inc = count_reg + 1'b1;

    always_comb
    begin
        phase_next  = phase_reg;
        class_next  = class_reg;
        ident_next  = ident_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        res_valid   = 1'b0;
        res_kind    = ubx_pkg::EV_DATA;
        res_length  = length_reg[8:0];
        res_data    = 8'd0;
        res_index   = 8'd0;

        if (accept)
        begin
            if (rx.func)
            begin
                phase_next = PH_SYNC1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_SYNC2:
                    begin
                        phase_next = (b == ubx_pkg::SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
                    end
                    PH_CLASS:
                    begin
                        class_next = b;
                        sum_a_next = b;
                        sum_b_next = b;
                        phase_next = PH_IDENT;
                    end
                    PH_IDENT:
                    begin
                        ident_next = b;
                        sum_a_next = add_a;
                        sum_b_next = add_b;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        length_next = {8'd0, b};
                        sum_a_next  = add_a;
                        sum_b_next  = add_b;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        length_next = len_full;
                        sum_a_next  = add_a;
                        sum_b_next  = add_b;
                        if (len_full > MaxLen)
                        begin
                            phase_next = PH_SYNC1;
                            res_valid  = 1'b1;
                            res_kind   = ubx_pkg::EV_DROP;
                            res_length = 9'd0;
                        end
                        else
                        begin
                            count_next = '0;
                            phase_next = (len_full == 16'd0) ? PH_CK_A : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        sum_a_next = add_a;
                        sum_b_next = add_b;
                        count_next = count_inc;
                        if (16'(count_inc) >= length_reg)
                            phase_next = PH_CK_A;
                        res_valid  = 1'b1;
                        res_kind   = ubx_pkg::EV_DATA;
                        res_data   = b;
                        res_index  = 8'(count_reg);
                    end
                    PH_CK_A:
                    begin
                        if (b == sum_a_reg)
                        begin
                            phase_next = PH_CK_B;
                        end
                        else
                        begin
                            phase_next = PH_SYNC1;
                            res_valid  = 1'b1;
                            res_kind   = ubx_pkg::EV_BAD;
                        end
                    end
                    PH_CK_B:
                    begin
                        phase_next = PH_SYNC1;
                        res_valid  = 1'b1;
                        res_kind   = (b == sum_b_reg) ? ubx_pkg::EV_GOOD : ubx_pkg::EV_BAD;
                    end
                    default:
                    begin
                        // first sync hunt, also taken by unused phase codes
                        phase_next = (b == ubx_pkg::SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            class_reg     <= 8'd0;
            ident_reg     <= 8'd0;
            length_reg    <= 16'd0;
            count_reg     <= '0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            class_reg  <= class_next;
            ident_reg  <= ident_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_a_reg  <= sum_a_next;
            sum_b_reg  <= sum_b_next;
            if (accept)
                out_valid_reg <= res_valid;
            else if (evt.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // event payload: class/id taken from the values in force for this byte
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg    <= res_kind;
            oclass_reg  <= class_next;
            oident_reg  <= ident_next;
            olength_reg <= res_length;
            odata_reg   <= res_data;
            oindex_reg  <= res_index;
        end
    end

    assign evt.valid      = out_valid_reg;
    assign evt.event_kind = kind_reg;
    assign evt.msg_class  = oclass_reg;
    assign evt.msg_ident  = oident_reg;
    assign evt.msg_length = olength_reg;
    assign evt.data_byte  = odata_reg;
    assign evt.byte_index = oindex_reg;

endmodule

`default_nettype wire
